// File: rtl/tbo_pkg.sv
// Shared types and constants for the triangle / cube overlap tester.
// No dependencies; imported by the top level.
package tbo_pkg;

    localparam int SIDE_BITS    = 31;
    localparam int TAG_BITS     = 24;
    localparam int CFG_IDX_BITS = 2;
    localparam int OUT_W        = ((TAG_BITS + 1 + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_SIDE     = 2'd3
    } t_cfg_reg;

    function automatic int nxt(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

endpackage

// File: rtl/triangle_box_overlap_test.sv
// Triangle / axis-aligned cube overlap tester, separating axis test over 13 axes.
// Depends on tbo_pkg and tbo_sep_test.
//
//  Channel     Signals                       Direction  Carries
//  s_axis      tvalid, tready, tdata         in         one triangle and its tag per beat
//  m_axis      tvalid, tready, tdata         out        tag and overlap flag per beat
//  cfg         valid, ready, index, data     in         cube centre and side length
//
// Each beat passes eight register stages before its result is on the output; the depth is
// set by the normal-axis path (edge products, normal, split projection products, sums,
// compare). One beat is accepted every cycle unless an output stall has backed up to the
// first stage. Reset is synchronous and clears all valid bits and restores the cube
// registers. A stall on the output holds each full stage, while empty stages ahead of it
// keep filling, so no beat is lost or repeated.
module triangle_box_overlap_test
    import tbo_pkg::*;
#(
    parameter int COORD_BITS = 32,
    localparam int IN_W  = ((9 * COORD_BITS + TAG_BITS + 7) / 8) * 8,
    localparam int CFG_W = (COORD_BITS > SIDE_BITS) ? COORD_BITS : SIDE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_tag, zero fill
    input  logic [IN_W-1:0]         i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // out_tag, overlaps, zero fill
    output logic [OUT_W-1:0]        o_m_axis_tdata,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);
    localparam int C    = COORD_BITS;
    localparam int V    = C + 1;
    localparam int E    = C + 2;
    localparam int PR   = V + E;
    localparam int PE   = PR + 1;
    localparam int ESW  = E + 1;
    localparam int RE   = SIDE_BITS + ESW;
    localparam int NP   = 2 * E;
    localparam int NB   = NP + 1;
    localparam int L    = NB / 2;
    localparam int PL   = V + L + 1;
    localparam int PH   = V + NB - L;
    localparam int PN   = V + NB + 1;
    localparam int NSW  = NB + 2;
    localparam int HL   = NSW / 2;
    localparam int RLW  = SIDE_BITS + HL;
    localparam int RHW  = SIDE_BITS + NSW - HL;
    localparam int RN   = SIDE_BITS + NSW + 1;
    localparam int NST  = 8;

    logic signed [C-1:0]         r_ctr [3];
    logic [SIDE_BITS-1:0]        r_side;

    logic [NST:1]                r_vld;
    logic [NST+1:1]              en;
    logic [TAG_BITS-1:0]         r_tag [1:NST];

    logic signed [V-1:0]         n1_v [3][3];
    logic signed [V-1:0]         r1_v [3][3];
    logic signed [V-1:0]         r2_v [3][3];
    logic signed [E-1:0]         n2_e [3][3];
    logic signed [E-1:0]         r2_e [3][3];

    logic signed [V-1:0]         r3_v [3][3];
    logic signed [PR-1:0]        n3_pa [9][3];
    logic signed [PR-1:0]        n3_pb [9][3];
    logic signed [PR-1:0]        r3_pa [9][3];
    logic signed [PR-1:0]        r3_pb [9][3];
    logic [E-1:0]                ae [3][3];
    logic [ESW-1:0]              n3_es [9];
    logic [ESW-1:0]              r3_es [9];
    logic signed [NP-1:0]        n3_na [3];
    logic signed [NP-1:0]        n3_nb [3];
    logic signed [NP-1:0]        r3_na [3];
    logic signed [NP-1:0]        r3_nb [3];
    logic signed [V-1:0]         box_p [3][3];
    logic [2:0]                  sep_box;
    logic                        r3_sep;

    logic signed [V-1:0]         r4_v [3][3];
    logic signed [PE-1:0]        n4_pe [9][3];
    logic signed [PE-1:0]        r4_pe [9][3];
    logic [RE-1:0]               n4_re [9];
    logic [RE-1:0]               r4_re [9];
    logic signed [NB-1:0]        n4_n [3];
    logic signed [NB-1:0]        r4_n [3];
    logic                        r4_sep;

    logic [8:0]                  sep_edge;
    logic signed [L:0]           n_lo [3];
    logic signed [NB-L-1:0]      n_hi [3];
    logic [NB-1:0]               an [3];
    logic signed [PL-1:0]        n5_plo [3][3];
    logic signed [PH-1:0]        n5_phi [3][3];
    logic signed [PL-1:0]        r5_plo [3][3];
    logic signed [PH-1:0]        r5_phi [3][3];
    logic [NSW-1:0]              n5_ns;
    logic [NSW-1:0]              r5_ns;
    logic                        r5_sep;

    logic signed [PN-1:0]        n6_t [3][3];
    logic signed [PN-1:0]        r6_t [3][3];
    logic [RLW-1:0]              r6_rlo;
    logic [RHW-1:0]              r6_rhi;
    logic                        r6_sep;

    logic signed [PN-1:0]        n7_pn [3];
    logic signed [PN-1:0]        r7_pn [3];
    logic [RN-1:0]               r7_rn;
    logic                        r7_sep;

    logic                        sep_norm;
    logic                        r8_ovl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr[0] <= '0;
            r_ctr[1] <= '0;
            r_ctr[2] <= '0;
            r_side   <= SIDE_BITS'(65536);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CENTER_X: r_ctr[0] <= i_cfg_data[C-1:0];
                REG_CENTER_Y: r_ctr[1] <= i_cfg_data[C-1:0];
                REG_CENTER_Z: r_ctr[2] <= i_cfg_data[C-1:0];
                REG_SIDE:     r_side   <= i_cfg_data[SIDE_BITS-1:0];
                default:      r_side   <= r_side;
            endcase
        end
    end

    always_comb begin
        en[NST+1] = i_m_axis_tready;
        for (int s = NST; s >= 1; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end
    assign o_s_axis_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int s = 2; s <= NST; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_tag[1] <= i_s_axis_tdata[9*C +: TAG_BITS];
        end
        for (int s = 2; s <= NST; s++) begin
            if (en[s]) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    // Vertices relative to the cube centre, then edges.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n1_v[i][k] = V'(signed'(i_s_axis_tdata[(i*3+k)*C +: C])) - V'(r_ctr[k]);
            end
        end
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                n2_e[j][k] = E'(r1_v[nxt(j)][k]) - E'(r1_v[j][k]);
            end
        end
    end

    // Edge-axis products, normal products and radius sums.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                ae[j][k] = r2_e[j][k][E-1] ? E'(-r2_e[j][k]) : E'(r2_e[j][k]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    n3_pa[k*3+j][i] = r2_v[i][nxt(nxt(k))] * r2_e[j][nxt(k)];
                    n3_pb[k*3+j][i] = r2_v[i][nxt(k)] * r2_e[j][nxt(nxt(k))];
                end
                n3_es[k*3+j] = ESW'(ae[j][nxt(k)]) + ESW'(ae[j][nxt(nxt(k))]);
            end
            n3_na[k] = r2_e[0][nxt(k)] * r2_e[1][nxt(nxt(k))];
            n3_nb[k] = r2_e[0][nxt(nxt(k))] * r2_e[1][nxt(k)];
            for (int i = 0; i < 3; i++) begin
                box_p[k][i] = r2_v[i][k];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_box
        tbo_sep_test #(.PW(V), .RW(SIDE_BITS)) u_sep (
            .i_proj (box_p[k]),
            .i_rad  (r_side),
            .o_sep  (sep_box[k])
        );
    end

    always_comb begin
        for (int m = 0; m < 9; m++) begin
            for (int i = 0; i < 3; i++) begin
                n4_pe[m][i] = PE'(r3_pa[m][i]) - PE'(r3_pb[m][i]);
            end
            n4_re[m] = RE'(r_side) * RE'(r3_es[m]);
        end
        for (int k = 0; k < 3; k++) begin
            n4_n[k] = NB'(r3_na[k]) - NB'(r3_nb[k]);
        end
    end

    for (genvar m = 0; m < 9; m++) begin : g_edge
        tbo_sep_test #(.PW(PE), .RW(RE)) u_sep (
            .i_proj (r4_pe[m]),
            .i_rad  (r4_re[m]),
            .o_sep  (sep_edge[m])
        );
    end

    // Normal axis: projections split into low and high partial products.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lo[k] = signed'({1'b0, r4_n[k][L-1:0]});
            n_hi[k] = r4_n[k][NB-1:L];
            an[k]   = r4_n[k][NB-1] ? NB'(-r4_n[k]) : NB'(r4_n[k]);
            for (int i = 0; i < 3; i++) begin
                n5_plo[i][k] = r4_v[i][k] * n_lo[k];
                n5_phi[i][k] = r4_v[i][k] * n_hi[k];
            end
        end
        n5_ns = NSW'(an[0]) + NSW'(an[1]) + NSW'(an[2]);
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n6_t[i][k] = (PN'(r5_phi[i][k]) <<< L) + PN'(r5_plo[i][k]);
            end
            n7_pn[i] = r6_t[i][0] + r6_t[i][1] + r6_t[i][2];
        end
    end

    tbo_sep_test #(.PW(PN), .RW(RN)) u_sep_norm (
        .i_proj (r7_pn),
        .i_rad  (r7_rn),
        .o_sep  (sep_norm)
    );

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_v <= n1_v;
        end
        if (en[2]) begin
            r2_v <= r1_v;
            r2_e <= n2_e;
        end
        if (en[3]) begin
            r3_v   <= r2_v;
            r3_pa  <= n3_pa;
            r3_pb  <= n3_pb;
            r3_es  <= n3_es;
            r3_na  <= n3_na;
            r3_nb  <= n3_nb;
            r3_sep <= |sep_box;
        end
        if (en[4]) begin
            r4_v   <= r3_v;
            r4_pe  <= n4_pe;
            r4_re  <= n4_re;
            r4_n   <= n4_n;
            r4_sep <= r3_sep;
        end
        if (en[5]) begin
            r5_plo <= n5_plo;
            r5_phi <= n5_phi;
            r5_ns  <= n5_ns;
            r5_sep <= r4_sep | (|sep_edge);
        end
        if (en[6]) begin
            r6_t   <= n6_t;
            r6_rlo <= RLW'(r_side) * RLW'(r5_ns[HL-1:0]);
            r6_rhi <= RHW'(r_side) * RHW'(r5_ns[NSW-1:HL]);
            r6_sep <= r5_sep;
        end
        if (en[7]) begin
            r7_pn  <= n7_pn;
            r7_rn  <= (RN'(r6_rhi) << HL) + RN'(r6_rlo);
            r7_sep <= r6_sep;
        end
        if (en[8]) begin
            r8_ovl <= !(r7_sep || sep_norm);
        end
    end

    assign o_m_axis_tvalid = r_vld[NST];
    assign o_m_axis_tdata  = {(OUT_W - TAG_BITS - 1)'(0), r8_ovl, r_tag[NST]};

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[1])
        else $error("accepted beat did not enter the first stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !en[4]) |=> (r_vld[4] && $stable(r_tag[4])))
        else $error("stalled middle stage lost or changed its beat");

    a_bubble_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[1] |-> o_s_axis_tready)
        else $error("empty first stage refused a beat");

    a_reach_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && en[NST]) |=> r_vld[NST])
        else $error("beat vanished before the output register");

endmodule

// File: rtl/tbo_sep_test.sv
// Separation check of one candidate axis: three projections against a radius.
// Purely combinational; used by the top level, no package needed.
module tbo_sep_test #(
    parameter int PW = 69,
    parameter int RW = 66
) (
    input  logic signed [PW-1:0] i_proj [3],
    input  logic        [RW-1:0] i_rad,
    output logic                 o_sep
);
    localparam int W = ((PW > RW) ? PW : RW) + 2;

    logic signed [W-1:0] rad_s;
    logic signed [W-1:0] twice [3];
    logic signed [W-1:0] neg_twice [3];
    logic [2:0] above;
    logic [2:0] below;

    always_comb begin
        rad_s = signed'(W'(i_rad));
        for (int i = 0; i < 3; i++) begin
            twice[i]     = W'(i_proj[i]) <<< 1;
            neg_twice[i] = -twice[i];
            above[i]     = twice[i] > rad_s;
            below[i]     = neg_twice[i] > rad_s;
        end
        o_sep = (&above) | (&below);
    end

endmodule
